// ===== rtl/trc_pkg.sv =====
// Shared types and constants for the triggered ring capture block.
// Used by every module of the block except the generic RAM and the remainder unit.
package trc_pkg;

  // Default ring buffer depth
  localparam int DEPTH_DEF = 1024;

  // Field widths
  localparam int SAMPLE_W = 32;
  localparam int RIDX_W   = 10;
  localparam int PTR_W    = 10;
  localparam int MODE_W   = 3;
  localparam int PRE_W    = 11;
  localparam int DEC_W    = 16;
  localparam int CNT_W    = 11;
  localparam int CFG_W    = 16;
  localparam int CFG_IW   = 2;

  // Stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  // Result queue depth
  localparam int QDEPTH = 4;

  // Register indexes
  localparam logic [CFG_IW-1:0] REG_MODE  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_PRE   = 2'd1;
  localparam logic [CFG_IW-1:0] REG_DECIM = 2'd2;
  localparam logic [CFG_IW-1:0] REG_COUNT = 2'd3;

  // Trigger modes
  localparam logic [MODE_W-1:0] MODE_NONE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RISE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FALL = 3'd2;
  localparam logic [MODE_W-1:0] MODE_HIGH = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LOW  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_RST  = 3'd7;

  // Remainder pass sequencer
  typedef enum logic [1:0] {
    NORM_IDLE,
    NORM_PRE,
    NORM_WP,
    NORM_TP
  } norm_state_t;

  // One result item
  typedef struct packed {
    logic                running;
    logic                triggered;
    logic                all_valid;
    logic [PTR_W-1:0]    write_index;
    logic [PTR_W-1:0]    trigger_index;
    logic                stored;
    logic                finished;
    logic [SAMPLE_W-1:0] read_data;
  } res_t;

  // Front to queue transfer
  typedef struct packed {
    logic valid;
    res_t res;
  } q_push_t;

endpackage

// ===== rtl/trc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Read-first: a read at the address being written returns the old word.
module trc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/trc_mod.sv =====
// Bit-serial remainder unit: dividend modulo divisor, one bit per cycle.
// Depends on nothing outside this file.
module trc_mod #(
  parameter int OPW = 11,
  parameter int RW  = 11
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           clear,
  input  logic           start,
  input  logic [OPW-1:0] dividend,
  input  logic [RW-1:0]  divisor,
  output logic           busy,
  output logic           done,
  output logic [RW-1:0]  remainder
);

  localparam int CW = $clog2(OPW + 1);

  logic [OPW-1:0] shreg;
  logic [RW-1:0]  dvsr;
  logic [RW-1:0]  rem;
  logic [CW-1:0]  cnt;
  logic [RW:0]    trial;
  logic [RW-1:0]  rem_next;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem, shreg[OPW-1]};
    if (trial >= {1'b0, dvsr}) begin
      rem_next = RW'(trial - {1'b0, dvsr});
    end else begin
      rem_next = trial[RW-1:0];
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CW'(OPW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      dvsr  <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[OPW-2:0], 1'b0};
      rem   <= rem_next;
    end
  end

  assign remainder = rem;

endmodule

// ===== rtl/trc_front.sv =====
// Front part: accepts sample ticks, runs the trigger and capture control,
// writes and reads the sample RAM, and hands results to the queue.
// Depends on trc_pkg, trc_ram and trc_mod.
module trc_front #(
  parameter int DEPTH = trc_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [trc_pkg::CFG_IW-1:0]          cfg_index,
  input  logic [trc_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [trc_pkg::IN_TDATA_W-1:0]      s_tdata,
  input  logic [$clog2(trc_pkg::QDEPTH):0]    q_level,
  output trc_pkg::q_push_t                    push
);
  import trc_pkg::*;

  localparam int AW  = $clog2(DEPTH);
  localparam int RW  = AW + 1;
  localparam int TW  = RW + 1;
  localparam int OPW = (AW > PRE_W) ? AW : PRE_W;
  localparam int QLW = $clog2(QDEPTH) + 1;

  // Input fields
  logic [SAMPLE_W-1:0] in_sample;
  logic                in_level;
  logic                in_arm;
  logic                in_manual;
  logic [RIDX_W-1:0]   in_ridx;

  assign in_sample = s_tdata[31:0];
  assign in_level  = s_tdata[32];
  assign in_arm    = s_tdata[33];
  assign in_manual = s_tdata[34];
  assign in_ridx   = s_tdata[44:35];

  // Configuration registers
  logic [MODE_W-1:0] cfg_mode;
  logic [PRE_W-1:0]  cfg_pre;
  logic [DEC_W-1:0]  cfg_decim;
  logic [CNT_W-1:0]  cfg_count;
  logic              renorm;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_mode  <= MODE_NONE;
      cfg_pre   <= '0;
      cfg_decim <= DEC_W'(1);
      cfg_count <= CNT_W'(DEPTH_DEF);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:  cfg_mode  <= cfg_data[MODE_W-1:0];
        REG_PRE:   cfg_pre   <= cfg_data[PRE_W-1:0];
        REG_DECIM: cfg_decim <= cfg_data[DEC_W-1:0];
        REG_COUNT: cfg_count <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // A new ring length or pre-trigger count needs the remainders redone
  assign renorm = cfg_we && (cfg_index == REG_PRE || cfg_index == REG_COUNT);

  // Ring length clamped to 1..DEPTH
  logic [CNT_W-1:0] count_eff;
  logic [RW-1:0]    ring;

  always_comb begin
    count_eff = (cfg_count == '0) ? CNT_W'(1) : cfg_count;
    if (32'(count_eff) > DEPTH) begin
      ring = RW'(DEPTH);
    end else begin
      ring = RW'(count_eff);
    end
  end

  // Capture state
  logic              running, running_next;
  logic              trig, trig_next;
  logic              manual, manual_next;
  logic [AW-1:0]     wp, wp_next;
  logic [AW-1:0]     tp, tp_next;
  logic [AW-1:0]     wp_mod, wp_mod_next;
  logic [AW-1:0]     tp_mod, tp_mod_next;
  logic [AW-1:0]     pre_mod;
  logic              full, full_next;
  logic [DEC_W-1:0]  dcnt, dcnt_next;
  logic [MODE_W-1:0] pmode, pmode_next;
  logic              plevel, plevel_next;
  logic              stored_c, finished_c;

  logic              accept;
  logic [RW-1:0]     wp_inc;
  logic [TW-1:0]     tgt_sum, tgt;
  logic              ref_level;
  logic              fire;

  // Remainder pass sequencer
  norm_state_t       state, state_next;
  logic              mod_start, mod_busy, mod_done;
  logic [OPW-1:0]    mod_dividend;
  logic [RW-1:0]     mod_rem;

  assign accept = s_tvalid && s_tready;

  // Tick update
  always_comb begin
    running_next = running;
    trig_next    = trig;
    manual_next  = manual;
    wp_next      = wp;
    tp_next      = tp;
    wp_mod_next  = wp_mod;
    tp_mod_next  = tp_mod;
    full_next    = full;
    dcnt_next    = dcnt;
    pmode_next   = pmode;
    plevel_next  = plevel;
    stored_c     = 1'b0;
    finished_c   = 1'b0;
    fire         = 1'b0;
    ref_level    = (pmode != cfg_mode) ? in_level : plevel;
    wp_inc       = RW'(wp) + RW'(1);
    tgt_sum      = '0;
    tgt          = '0;

    if (in_arm)    running_next = 1'b1;
    if (in_manual) manual_next  = 1'b1;

    if (running_next) begin
      // Trigger search
      if (!trig) begin
        fire = manual_next;
        if (!fire && cfg_mode != MODE_NONE) begin
          case (cfg_mode)
            MODE_RISE: fire = !ref_level && in_level;
            MODE_FALL: fire = ref_level && !in_level;
            MODE_HIGH: fire = in_level;
            MODE_LOW:  fire = !in_level;
            default:   fire = 1'b0;
          endcase
          pmode_next  = cfg_mode;
          plevel_next = in_level;
        end
        if (fire) begin
          tp_next     = wp;
          tp_mod_next = wp_mod;
          trig_next   = 1'b1;
        end
      end

      // Store and stop test
      if (dcnt == '0) begin
        stored_c = 1'b1;
        if (wp_inc >= ring) begin
          full_next = 1'b1;
          wp_next   = '0;
        end else begin
          wp_next = AW'(wp_inc);
        end
        wp_mod_next = wp_next;
        if (trig_next) begin
          tgt_sum = TW'(tp_mod_next) + TW'(ring) - TW'(pre_mod);
          tgt     = (tgt_sum >= TW'(ring)) ? tgt_sum - TW'(ring) : tgt_sum;
          if (tgt == TW'(wp_next)) begin
            running_next = 1'b0;
            trig_next    = 1'b0;
            manual_next  = 1'b0;
            finished_c   = 1'b1;
          end
        end
        dcnt_next = cfg_decim - DEC_W'(1);
      end else begin
        dcnt_next = dcnt - DEC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      trig    <= 1'b0;
      manual  <= 1'b0;
      wp      <= '0;
      tp      <= '0;
      wp_mod  <= '0;
      tp_mod  <= '0;
      pre_mod <= '0;
      full    <= 1'b0;
      dcnt    <= '0;
      pmode   <= MODE_RST;
      plevel  <= 1'b0;
    end else if (accept) begin
      running <= running_next;
      trig    <= trig_next;
      manual  <= manual_next;
      wp      <= wp_next;
      tp      <= tp_next;
      wp_mod  <= wp_mod_next;
      tp_mod  <= tp_mod_next;
      full    <= full_next;
      dcnt    <= dcnt_next;
      pmode   <= pmode_next;
      plevel  <= plevel_next;
    end else if (mod_done) begin
      case (state)
        NORM_PRE: pre_mod <= AW'(mod_rem);
        NORM_WP:  wp_mod  <= AW'(mod_rem);
        NORM_TP:  tp_mod  <= AW'(mod_rem);
        default: ;
      endcase
    end
  end

  // Sample RAM: write at the pointer, read the requested entry
  logic [SAMPLE_W-1:0] ram_rdata;

  trc_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (accept && stored_c),
    .waddr (wp),
    .wdata (in_sample),
    .raddr (AW'(in_ridx)),
    .rdata (ram_rdata)
  );

  // Result stage, completed by the registered RAM read data
  logic st_valid;
  logic st_oob;
  res_t st;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else begin
      st_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_oob           <= (32'(in_ridx) >= DEPTH);
      st.running       <= running_next;
      st.triggered     <= trig_next;
      st.all_valid     <= full_next;
      st.write_index   <= PTR_W'(wp_next);
      st.trigger_index <= PTR_W'(tp_next);
      st.stored        <= stored_c;
      st.finished      <= finished_c;
      st.read_data     <= '0;
    end
  end

  always_comb begin
    push.valid         = st_valid;
    push.res           = st;
    push.res.read_data = st_oob ? '0 : ram_rdata;
  end

  // Room for this item counting the one still in the result stage
  assign s_tready = ((QLW + 1)'(q_level) + (QLW + 1)'(st_valid) < (QLW + 1)'(QDEPTH))
                    && state == NORM_IDLE && !renorm;

  // Sequencer next state
  always_comb begin
    state_next = state;
    if (renorm) begin
      state_next = NORM_PRE;
    end else begin
      case (state)
        NORM_IDLE: state_next = NORM_IDLE;
        NORM_PRE:  if (mod_done) state_next = NORM_WP;
        NORM_WP:   if (mod_done) state_next = NORM_TP;
        NORM_TP:   if (mod_done) state_next = NORM_IDLE;
        default:   state_next = NORM_IDLE;
      endcase
    end
  end

  // Sequencer outputs
  always_comb begin
    mod_start = (state != NORM_IDLE) && !mod_busy && !mod_done && !renorm;
    case (state)
      NORM_PRE: mod_dividend = OPW'(cfg_pre);
      NORM_WP:  mod_dividend = OPW'(wp);
      NORM_TP:  mod_dividend = OPW'(tp);
      default:  mod_dividend = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= NORM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  trc_mod #(
    .OPW (OPW),
    .RW  (RW)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .clear     (renorm),
    .start     (mod_start),
    .dividend  (mod_dividend),
    .divisor   (ring),
    .busy      (mod_busy),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // Checks
  a_finish_clears : assert property (@(posedge clk) disable iff (rst)
    st_valid && st.finished |-> !st.running && !st.triggered)
    else $error("finished result still shows running or triggered");

  a_no_accept_norm : assert property (@(posedge clk) disable iff (rst)
    state != NORM_IDLE |-> !s_tready)
    else $error("input accepted during remainder pass");

  a_wp_in_ring : assert property (@(posedge clk) disable iff (rst)
    st_valid && st.stored |-> (wp_mod == wp) && (RW'(wp) < ring))
    else $error("write pointer outside ring after a store");

endmodule

// ===== rtl/trc_queue.sv =====
// Back part: short result queue that drives the master-side stream.
// Depends on trc_pkg.
module trc_queue (
  input  logic                              clk,
  input  logic                              rst,
  input  trc_pkg::q_push_t                  push,
  output logic [$clog2(trc_pkg::QDEPTH):0]  level,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output trc_pkg::res_t                     head
);
  import trc_pkg::*;

  localparam int QAW = $clog2(QDEPTH);

  res_t           entries [QDEPTH];
  logic [QAW-1:0] wr, rd;
  logic [QAW:0]   count;
  logic           pop;

  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (count != '0);
  assign head     = entries[rd];
  assign level    = count;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      if (push.valid) wr <= (wr == QAW'(QDEPTH - 1)) ? '0 : wr + 1'b1;
      if (pop)        rd <= (rd == QAW'(QDEPTH - 1)) ? '0 : rd + 1'b1;
      count <= count + (QAW + 1)'(push.valid) - (QAW + 1)'(pop);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr] <= push.res;
    end
  end

  // Checks
  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    push.valid |-> (count < (QAW + 1)'(QDEPTH) || pop))
    else $error("result queue overflow");

  a_level_track : assert property (@(posedge clk) disable iff (rst)
    ##1 !$past(rst) |-> count == $past(count) + (QAW + 1)'($past(push.valid))
                                - (QAW + 1)'($past(pop)))
    else $error("queue level does not follow transactions");

  a_empty_ptrs : assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> rd == wr)
    else $error("empty queue with pointers apart");

endmodule

// ===== rtl/triggered_ring_capture.sv =====
// Triggered ring capture: top level joining the capture front, the result
// queue and the output stream. Depends on trc_pkg, trc_front, trc_queue.
//
// One input transaction is one sample tick and yields exactly one result
// transaction. The block takes one tick per clock while s_tready is high;
// each result passes the registered sample RAM read, then the four-entry
// result queue, so stalls on the output side are absorbed by the queue
// before s_tready drops. A write to pre_trigger_samples or sample_count
// starts a bit-serial remainder pass that brings the pre-trigger count,
// write pointer and trigger pointer into the new ring; s_tready is low in
// the write cycle and until the pass ends. Sample RAM entries are undefined
// until written; read_data of such an entry is meaningless.
module triggered_ring_capture #(
  parameter int DEPTH = trc_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [trc_pkg::CFG_IW-1:0]       cfg_index,
  input  logic [trc_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // sample[31:0], trigger_level[32], arm[33], manual_trigger[34],
  // read_index[44:35], zero pad[47:45]
  input  logic [trc_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // running[0], triggered[1], all_valid[2], write_index[12:3],
  // trigger_index[22:13], stored[23], read_data[55:24]
  output logic [trc_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // finished
  output logic                             m_tlast
);
  import trc_pkg::*;

  q_push_t                  push;
  logic [$clog2(QDEPTH):0]  q_level;
  res_t                     head;

  trc_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_level   (q_level),
    .push      (push)
  );

  trc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .level    (q_level),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .head     (head)
  );

  // Output packing
  assign m_tdata = {head.read_data, head.stored, head.trigger_index,
                    head.write_index, head.all_valid, head.triggered, head.running};
  assign m_tlast = head.finished;

endmodule
